@@ rtl/itrd_pkg.sv @@
// shared constants, types and digit encoding for the radix digit converter
package itrd_pkg;

  localparam int VALUE_W    = 31;
  localparam int RADIX_W    = 6;
  localparam int CHAR_W     = 7;
  localparam int MAX_DIGITS = 32;
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int BIT_W      = $clog2(VALUE_W);
  localparam int MAX_EMIT   = 31;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] DEC_LIMIT   = RADIX_W'(10);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  CHAR_ALPHA  = CHAR_W'(65);

  typedef struct packed {
    logic load;
    logic div_step;
    logic store;
    logic rd;
    logic emit;
  } itrd_cmd_t;

  typedef struct packed {
    logic div_last;
    logic more;
    logic idx_zero;
  } itrd_sts_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = CHAR_W'(d);
    if (d < DEC_LIMIT) begin
      digit_to_char = CHAR_ZERO + d_ext;
    end else begin
      digit_to_char = CHAR_ALPHA + d_ext - CHAR_W'(DEC_LIMIT);
    end
  endfunction

  function automatic logic [RADIX_W-1:0] sat_base(input logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) begin
      sat_base = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      sat_base = RADIX_MAX;
    end else begin
      sat_base = r;
    end
  endfunction

endpackage

@@ rtl/integer_to_radix_digits.sv @@
// top level of the integer to radix digit string converter
//
// usage: raise start with in_value while busy is low; the word is taken on
// that edge and busy rises on the next cycle
// the base comes from cfg_radix, written with cfg_we while idle; codes
// below 2 act as 2 and codes above 36 act as 36; reset value is 10
// each digit is divided out on a one-bit-per-cycle restoring divider,
// and the remainder is then stored to the digit memory
// digits leave most significant first, each read from memory and then
// output, each on out_digit_char for one cycle with out_valid
// high; out_last_digit marks the final digit; zero gives a single '0'
// the next word is taken after the last digit
// the receiver cannot stall; out_valid strobes are never held back
// reset clears the controller to idle and the base to 10
module integer_to_radix_digits
  import itrd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               cfg_we,
  input  logic [RADIX_W-1:0] cfg_radix,
  output logic               out_valid,
  output logic [CHAR_W-1:0]  out_digit_char,
  output logic               out_last_digit
);

  itrd_cmd_t cmd;
  itrd_sts_t sts;

  itrd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .sts       (sts),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  itrd_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_radix),
    .in_value       (in_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

endmodule

@@ rtl/itrd_ctrl.sv @@
// control state machine for the radix digit converter
module itrd_ctrl
  import itrd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  itrd_sts_t sts,
  output itrd_cmd_t cmd,
  output logic      out_valid
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_STORE = 5'b00100,
    ST_RD    = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        state_nxt = sts.more ? ST_DIV : ST_RD;
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        cmd.emit  = 1'b1;
        state_nxt = sts.idx_zero ? ST_IDLE : ST_RD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

endmodule

@@ rtl/itrd_dp.sv @@
// datapath: radix register, bit-serial divider, digit memory and char encode
module itrd_dp
  import itrd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [RADIX_W-1:0] cfg_wdata,
  input  logic [VALUE_W-1:0] in_value,
  input  itrd_cmd_t          cmd,
  output itrd_sts_t          sts,
  output logic [CHAR_W-1:0]  out_digit_char,
  output logic               out_last_digit
);

  logic [RADIX_W-1:0] radix_r;
  logic [RADIX_W-1:0] base_r;
  logic [VALUE_W-1:0] quot_r;
  logic [RADIX_W-1:0] rem_r;
  logic [BIT_W-1:0]   bit_cnt_r;
  logic [CNT_W-1:0]   ndig_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic [RADIX_W-1:0] rd_data_r;
  logic [RADIX_W-1:0] mem [MAX_DIGITS];

  logic [RADIX_W:0]   rem_sh;
  logic               ge;
  logic [RADIX_W-1:0] rem_nxt;
  logic [CNT_W-1:0]   ndig_inc;
  logic [IDX_W-1:0]   rd_idx_init;

  assign rem_sh   = {rem_r, quot_r[VALUE_W-1]};
  assign ge       = (rem_sh >= {1'b0, base_r});
  assign rem_nxt  = ge ? RADIX_W'(rem_sh - {1'b0, base_r}) : rem_sh[RADIX_W-1:0];
  assign ndig_inc = ndig_r + CNT_W'(1);

  always_comb begin
    if (ndig_r >= CNT_W'(MAX_EMIT)) begin
      rd_idx_init = IDX_W'(MAX_EMIT - 1);
    end else begin
      rd_idx_init = ndig_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_we) begin
      radix_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quot_r    <= in_value;
      rem_r     <= '0;
      bit_cnt_r <= '0;
      base_r    <= sat_base(radix_r);
      ndig_r    <= '0;
    end else if (cmd.div_step) begin
      quot_r    <= {quot_r[VALUE_W-2:0], ge};
      rem_r     <= rem_nxt;
      bit_cnt_r <= bit_cnt_r + BIT_W'(1);
    end else if (cmd.store) begin
      rem_r     <= '0;
      bit_cnt_r <= '0;
      ndig_r    <= ndig_inc;
      rd_idx_r  <= rd_idx_init;
    end else if (cmd.emit) begin
      rd_idx_r  <= rd_idx_r - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[ndig_r[IDX_W-1:0]] <= rem_r;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  assign sts.div_last = (bit_cnt_r == BIT_W'(VALUE_W - 1));
  assign sts.more     = (quot_r != '0) && (ndig_inc < CNT_W'(MAX_DIGITS));
  assign sts.idx_zero = (rd_idx_r == '0);

  assign out_digit_char = digit_to_char(rd_data_r);
  assign out_last_digit = (rd_idx_r == '0);

endmodule
